FILE: rtl/wbps_pkg.sv
package wbps_pkg;

   // Sizing of the pattern window and the offset counter
   localparam int PATTERN_MAX = 16;
   localparam int OFFSET_BITS = 32;
   localparam int REG_BYTES   = 16;
   localparam int EFF_MAX     = (PATTERN_MAX < REG_BYTES) ? PATTERN_MAX : REG_BYTES;
   localparam int WIN_DEPTH   = PATTERN_MAX - 1;
   localparam int LEN_W       = 5;
   localparam int IDX_W       = 4;
   localparam int FILL_W      = $clog2(PATTERN_MAX + 1);
   localparam int ADDR_W      = 64;
   localparam int DATA_W      = 64;
   localparam int TOTAL_W     = 13;
   localparam int CSR_INDEX_W = 3;

   localparam logic [TOTAL_W-1:0] RESULT_LIMIT_RESET = TOTAL_W'(4096);

   // Result queue sizing
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 2);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_LENGTH = 3'd0,
      CSR_PATTERN_LOW    = 3'd1,
      CSR_PATTERN_HIGH   = 3'd2,
      CSR_WILDCARD_MASK  = 3'd3,
      CSR_BASE_ADDRESS   = 3'd4,
      CSR_RESULT_LIMIT   = 3'd5
   } csr_index_type;

   typedef enum logic {
      KIND_MATCH = 1'b0,
      KIND_COUNT = 1'b1
   } result_kind_type;

   // One queued scan outcome: an optional match item and an optional count item
   typedef struct packed {
      logic                has_match;
      logic                has_count;
      logic [ADDR_W-1:0]   addr;
      logic [TOTAL_W-1:0]  total;
   } entry_type;

   function automatic logic [7:0] pattern_byte(input logic [8*REG_BYTES-1:0] bytes,
                                               input logic [IDX_W-1:0] idx);
      return bytes[8*idx +: 8];
   endfunction

endpackage

FILE: rtl/wbps_ifs.sv
interface wbps_req_if;
   import wbps_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_buffer;

   modport source (output valid, output data_byte, output end_of_buffer, input ready);
   modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface wbps_rsp_if;
   import wbps_pkg::*;
   logic               valid;
   logic               ready;
   logic               result_kind;
   logic [ADDR_W-1:0]  match_address;
   logic [TOTAL_W-1:0] match_total;
   logic               last_of_run;

   modport source (output valid, output result_kind, output match_address,
                   output match_total, output last_of_run, input ready);
   modport sink   (input valid, input result_kind, input match_address,
                   input match_total, input last_of_run, output ready);
endinterface

interface wbps_csr_if;
   import wbps_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [DATA_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/wbps_cell.sv
module wbps_cell (
   input  logic       clock,
   input  logic       advance,
   input  logic [7:0] byte_in,
   input  logic [7:0] pat_byte,
   input  logic       care,
   output logic [7:0] byte_out,
   output logic       ok
);
   import wbps_pkg::*;

   logic [7:0] byte_ff;

   // Shift the window by one byte per transaction
   always_ff @(posedge clock) begin
      if (advance) begin
         byte_ff <= byte_in;
      end
   end

   // Compare the held byte against the pattern byte aligned to this age
   assign ok       = !care || (byte_ff == pat_byte);
   assign byte_out = byte_ff;

endmodule

FILE: rtl/wbps_out_queue.sv
module wbps_out_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  wbps_pkg::entry_type       push_entry,
   output logic [wbps_pkg::QCNT_W-1:0] level,
   wbps_rsp_if.source                rsp_if
);
   import wbps_pkg::*;

   entry_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               phase_ff, phase_in;
   entry_type          head;
   logic               show_count;
   logic               final_item;
   logic               rsp_fire;
   logic               pop;

   // Present the head entry: match item first, then the count item
   assign head       = mem_ff[rd_ptr_ff];
   assign show_count = phase_ff || !head.has_match;
   assign final_item = show_count || !head.has_count;
   assign rsp_fire   = rsp_if.valid && rsp_if.ready;
   assign pop        = rsp_fire && final_item;

   assign rsp_if.valid         = (count_ff != '0);
   assign rsp_if.result_kind   = show_count ? KIND_COUNT : KIND_MATCH;
   assign rsp_if.match_address = show_count ? '0 : head.addr;
   assign rsp_if.match_total   = head.total;
   assign rsp_if.last_of_run   = final_item;
   assign level                = count_ff;

   // Advance pointers, fill level and item phase
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      phase_in  = phase_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (rsp_fire) begin
         phase_in = !final_item;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         phase_ff  <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         phase_ff  <= phase_in;
      end
   end

   // Store pushed entries
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("result queue level above depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < QCNT_W'(QUEUE_DEPTH)))
      else $error("push into a full result queue");

   a_phase_pair: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (count_ff != '0) && head.has_match && head.has_count)
      else $error("count phase without a match and count pair at the head");

endmodule

FILE: rtl/wildcard_byte_pattern_scanner.sv
// Wildcard byte pattern scanner.
// req_if carries one buffer byte per transaction with end_of_buffer on the
// final byte. csr_if writes the configuration registers by index (pattern
// length, pattern bytes low and high, wildcard mask, base address, result
// limit); it is always ready and unknown indexes are dropped. rsp_if returns
// a match item with the window start address for every hit until the result
// limit, and one count item after the final byte; last_of_run flags the final
// item caused by a byte.
// Throughput: one byte per cycle while ready is high. The window is a row of
// byte cells, each comparing its held byte against the pattern byte aligned to
// its age, so the whole window is checked in the acceptance cycle.
// A result of a byte passes the compare stage register, then the queue entry
// with the base address added, before it is offered on rsp_if.
// A four-entry result queue decouples the two sides; ready drops only when
// the queue and the stage in front of it hold four entries, so a stalled
// receiver backs up into req_if after at most four pending transactions.
// Reset clears the counters, the queue and the registers (result limit 4096).
module wildcard_byte_pattern_scanner (
   input  logic       clock,
   input  logic       reset,
   wbps_req_if.sink   req_if,
   wbps_rsp_if.source rsp_if,
   wbps_csr_if.sink   csr_if
);
   import wbps_pkg::*;

   logic [LEN_W-1:0]       pattern_length_ff;
   logic [DATA_W-1:0]      pattern_low_ff;
   logic [DATA_W-1:0]      pattern_high_ff;
   logic [REG_BYTES-1:0]   wildcard_ff;
   logic [ADDR_W-1:0]      base_ff;
   logic [TOTAL_W-1:0]     limit_ff;

   logic [FILL_W-1:0]      fill_ff;
   logic [OFFSET_BITS-1:0] bytes_seen_ff;
   logic [TOTAL_W-1:0]     matches_ff;

   logic                   s1_valid_ff;
   logic                   s1_has_match_ff;
   logic                   s1_has_count_ff;
   logic [OFFSET_BITS-1:0] s1_off_ff;
   logic [TOTAL_W-1:0]     s1_total_ff;

   logic                   csr_fire;
   logic                   accept;
   logic [LEN_W-1:0]       len_eff;
   logic [8*REG_BYTES-1:0] pattern_all;
   logic [7:0]             age_pat [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] age_care;
   logic [PATTERN_MAX-1:0] age_ok;
   logic [7:0]             win [WIN_DEPTH];
   logic [FILL_W-1:0]      fill_next;
   logic                   hit;
   logic [TOTAL_W-1:0]     matches_next;
   logic [OFFSET_BITS-1:0] offset;
   logic [QCNT_W-1:0]      level;
   logic                   push;
   entry_type              push_entry;

   // Register writes
   assign csr_fire     = csr_if.valid && csr_if.ready;
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= '0;
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         wildcard_ff       <= '0;
         base_ff           <= '0;
         limit_ff          <= RESULT_LIMIT_RESET;
      end else if (csr_fire) begin
         case (csr_index_type'(csr_if.index))
            CSR_PATTERN_LENGTH: pattern_length_ff <= csr_if.data[LEN_W-1:0];
            CSR_PATTERN_LOW:    pattern_low_ff    <= csr_if.data;
            CSR_PATTERN_HIGH:   pattern_high_ff   <= csr_if.data;
            CSR_WILDCARD_MASK:  wildcard_ff       <= csr_if.data[REG_BYTES-1:0];
            CSR_BASE_ADDRESS:   base_ff           <= csr_if.data;
            CSR_RESULT_LIMIT:   limit_ff          <= csr_if.data[TOTAL_W-1:0];
            default: ;
         endcase
      end
   end

   // Saturate the pattern length to what the window and registers hold
   assign len_eff     = (pattern_length_ff > LEN_W'(EFF_MAX)) ? LEN_W'(EFF_MAX)
                                                              : pattern_length_ff;
   assign pattern_all = {pattern_high_ff, pattern_low_ff};

   // Align the pattern to window ages: age a meets pattern position len-1-a
   for (genvar a = 0; a < PATTERN_MAX; a++) begin : g_align
      logic             in_use;
      logic [IDX_W-1:0] idx;
      assign in_use      = (32'(len_eff) > a);
      assign idx         = IDX_W'(len_eff - LEN_W'(1) - LEN_W'(a));
      assign age_care[a] = in_use && !wildcard_ff[idx];
      assign age_pat[a]  = pattern_byte(pattern_all, idx);
   end

   // Current byte compares directly; older bytes live in the cell row
   assign accept    = req_if.valid && req_if.ready;
   assign win[0]    = req_if.data_byte;
   assign age_ok[0] = !age_care[0] || (req_if.data_byte == age_pat[0]);

   for (genvar k = 0; k < WIN_DEPTH; k++) begin : g_cell
      if (k < WIN_DEPTH - 1) begin : g_mid
         wbps_cell u_cell (
            .clock    (clock),
            .advance  (accept),
            .byte_in  (win[k]),
            .pat_byte (age_pat[k+1]),
            .care     (age_care[k+1]),
            .byte_out (win[k+1]),
            .ok       (age_ok[k+1])
         );
      end else begin : g_tail
         wbps_cell u_cell (
            .clock    (clock),
            .advance  (accept),
            .byte_in  (win[k]),
            .pat_byte (age_pat[k+1]),
            .care     (age_care[k+1]),
            .byte_out (),
            .ok       (age_ok[k+1])
         );
      end
   end

   // Decide the hit for the accepted byte
   always_comb begin
      fill_next    = (fill_ff == FILL_W'(PATTERN_MAX)) ? fill_ff : fill_ff + FILL_W'(1);
      hit          = (len_eff != '0) && (32'(fill_next) >= 32'(len_eff)) &&
                     (matches_ff < limit_ff) && (&age_ok);
      matches_next = hit ? matches_ff + TOTAL_W'(1) : matches_ff;
      offset       = bytes_seen_ff - OFFSET_BITS'(len_eff) + OFFSET_BITS'(1);
   end

   // Per-buffer counters; clear them after the final byte
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         bytes_seen_ff <= '0;
         matches_ff    <= '0;
      end else if (accept) begin
         if (req_if.end_of_buffer) begin
            fill_ff       <= '0;
            bytes_seen_ff <= '0;
            matches_ff    <= '0;
         end else begin
            fill_ff       <= fill_next;
            bytes_seen_ff <= bytes_seen_ff + OFFSET_BITS'(1);
            matches_ff    <= matches_next;
         end
      end
   end

   // Compare stage register; hold only transactions that produce results
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept && (hit || req_if.end_of_buffer);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_has_match_ff <= hit;
         s1_has_count_ff <= req_if.end_of_buffer;
         s1_off_ff       <= offset;
         s1_total_ff     <= matches_next;
      end
   end

   // Add the base address and push into the result queue
   assign push                 = s1_valid_ff;
   assign push_entry.has_match = s1_has_match_ff;
   assign push_entry.has_count = s1_has_count_ff;
   assign push_entry.addr      = base_ff + ADDR_W'(s1_off_ff);
   assign push_entry.total     = s1_total_ff;

   wbps_out_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .level      (level),
      .rsp_if     (rsp_if)
   );

   // Accept only while the queue has room for everything in flight
   assign req_if.ready = (level + QCNT_W'(s1_valid_ff)) < QCNT_W'(QUEUE_DEPTH);

   a_buffer_clear: assert property (@(posedge clock) disable iff (reset)
      accept && req_if.end_of_buffer |=>
         (bytes_seen_ff == '0) && (matches_ff == '0) && (fill_ff == '0))
      else $error("per-buffer state not cleared after the final byte");

endmodule
